// File: rtl/avrdec_pkg.sv
// ----------------------------------------------------------------------------
// avrdec_pkg
// Mnemonic codes shared by the decoder core and the top level.
// ----------------------------------------------------------------------------
package avrdec_pkg;

   localparam int unsigned OPCODE_W   = 32;
   localparam int unsigned MNEMONIC_W = 7;

   typedef enum logic [MNEMONIC_W-1:0] {
      MN_INVALID, MN_LDS, MN_STS, MN_JMP, MN_CALL, MN_BREAK, MN_NOP, MN_MOVW,
      MN_MULS, MN_CPC, MN_SBC, MN_ADD, MN_CP, MN_SUB, MN_ADC, MN_AND, MN_EOR,
      MN_OR, MN_MOV, MN_CPI, MN_SBCI, MN_SUBI, MN_ORI, MN_ANDI, MN_LDD, MN_STD,
      MN_LD, MN_LPM, MN_ELPM, MN_POP, MN_PUSH, MN_ST, MN_SEC, MN_IJMP, MN_SET,
      MN_SEI, MN_CLT, MN_CLI, MN_SLEEP, MN_WDR, MN_RET, MN_ICALL, MN_RETI,
      MN_COM, MN_NEG, MN_SWAP, MN_INC, MN_ASR, MN_LSR, MN_ROR, MN_DEC, MN_ADIW,
      MN_SBIW, MN_CBI, MN_SBI, MN_SBIS, MN_MUL, MN_IN, MN_OUT, MN_EXIT,
      MN_RJMP, MN_RCALL, MN_LDI, MN_BRCS, MN_BREQ, MN_BRMI, MN_BRLT, MN_BRTS,
      MN_BRPL, MN_BRCC, MN_BRNE, MN_BRGE, MN_BRTC, MN_BLD, MN_BST, MN_SBRC,
      MN_SBRS
   } mnemonic_type;

endpackage

// File: rtl/avrdec_core.sv
// ----------------------------------------------------------------------------
// avrdec_core
// Combinational classification of one opcode word into a mnemonic code.
// Long two-word forms are tested on bits 31:16 first, then bits 15:0.
// ----------------------------------------------------------------------------
module avrdec_core (
   input  logic [avrdec_pkg::OPCODE_W-1:0] opcode_word,
   output avrdec_pkg::mnemonic_type        mnemonic
);

   logic [7:0] hi;
   logic [7:0] b2;
   logic [7:0] major;
   logic [7:0] minor;
   logic [3:0] nib;

   assign hi    = opcode_word[31:24];
   assign b2    = opcode_word[23:16];
   assign major = opcode_word[15:8];
   assign minor = opcode_word[7:0];
   assign nib   = opcode_word[3:0];

   function automatic avrdec_pkg::mnemonic_type quad_group(input logic [3:0] idx);
      case (idx)
         4'd1:    quad_group = avrdec_pkg::MN_CPC;
         4'd2:    quad_group = avrdec_pkg::MN_SBC;
         4'd3:    quad_group = avrdec_pkg::MN_ADD;
         4'd5:    quad_group = avrdec_pkg::MN_CP;
         4'd6:    quad_group = avrdec_pkg::MN_SUB;
         4'd7:    quad_group = avrdec_pkg::MN_ADC;
         4'd8:    quad_group = avrdec_pkg::MN_AND;
         4'd9:    quad_group = avrdec_pkg::MN_EOR;
         4'd10:   quad_group = avrdec_pkg::MN_OR;
         4'd11:   quad_group = avrdec_pkg::MN_MOV;
         default: quad_group = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type imm_group(input logic [2:0] idx);
      case (idx)
         3'd3:    imm_group = avrdec_pkg::MN_CPI;
         3'd4:    imm_group = avrdec_pkg::MN_SBCI;
         3'd5:    imm_group = avrdec_pkg::MN_SUBI;
         3'd6:    imm_group = avrdec_pkg::MN_ORI;
         3'd7:    imm_group = avrdec_pkg::MN_ANDI;
         default: imm_group = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type load_nib(input logic [3:0] n);
      case (n)
         4'h0:    load_nib = avrdec_pkg::MN_LDS;
         4'h1:    load_nib = avrdec_pkg::MN_LD;
         4'h2:    load_nib = avrdec_pkg::MN_LD;
         4'h4:    load_nib = avrdec_pkg::MN_LPM;
         4'h5:    load_nib = avrdec_pkg::MN_LPM;
         4'h7:    load_nib = avrdec_pkg::MN_ELPM;
         4'h9:    load_nib = avrdec_pkg::MN_LD;
         4'hA:    load_nib = avrdec_pkg::MN_LD;
         4'hC:    load_nib = avrdec_pkg::MN_LD;
         4'hD:    load_nib = avrdec_pkg::MN_LD;
         4'hF:    load_nib = avrdec_pkg::MN_POP;
         default: load_nib = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type store_nib(input logic [3:0] n);
      case (n)
         4'h0:    store_nib = avrdec_pkg::MN_STS;
         4'h1:    store_nib = avrdec_pkg::MN_STD;
         4'h2:    store_nib = avrdec_pkg::MN_STD;
         4'h9:    store_nib = avrdec_pkg::MN_STD;
         4'hA:    store_nib = avrdec_pkg::MN_STD;
         4'hC:    store_nib = avrdec_pkg::MN_ST;
         4'hD:    store_nib = avrdec_pkg::MN_ST;
         4'hE:    store_nib = avrdec_pkg::MN_ST;
         4'hF:    store_nib = avrdec_pkg::MN_PUSH;
         default: store_nib = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type unary_nib(input logic [3:0] n);
      case (n)
         4'h0:    unary_nib = avrdec_pkg::MN_COM;
         4'h1:    unary_nib = avrdec_pkg::MN_NEG;
         4'h2:    unary_nib = avrdec_pkg::MN_SWAP;
         4'h3:    unary_nib = avrdec_pkg::MN_INC;
         4'h5:    unary_nib = avrdec_pkg::MN_ASR;
         4'h6:    unary_nib = avrdec_pkg::MN_LSR;
         4'h7:    unary_nib = avrdec_pkg::MN_ROR;
         4'hA:    unary_nib = avrdec_pkg::MN_DEC;
         default: unary_nib = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type decode_9x(input logic [15:0] w);
      case (w)
         16'h9408: decode_9x = avrdec_pkg::MN_SEC;
         16'h9409: decode_9x = avrdec_pkg::MN_IJMP;
         16'h9468: decode_9x = avrdec_pkg::MN_SET;
         16'h9478: decode_9x = avrdec_pkg::MN_SEI;
         16'h94E8: decode_9x = avrdec_pkg::MN_CLT;
         16'h94F8: decode_9x = avrdec_pkg::MN_CLI;
         16'h9588: decode_9x = avrdec_pkg::MN_SLEEP;
         16'h95A8: decode_9x = avrdec_pkg::MN_WDR;
         16'h9508: decode_9x = avrdec_pkg::MN_RET;
         16'h9509: decode_9x = avrdec_pkg::MN_ICALL;
         16'h9518: decode_9x = avrdec_pkg::MN_RETI;
         default:  decode_9x = unary_nib(w[3:0]);
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type brset(input logic [2:0] c);
      case (c)
         3'd0:    brset = avrdec_pkg::MN_BRCS;
         3'd1:    brset = avrdec_pkg::MN_BREQ;
         3'd2:    brset = avrdec_pkg::MN_BRMI;
         3'd4:    brset = avrdec_pkg::MN_BRLT;
         3'd6:    brset = avrdec_pkg::MN_BRTS;
         default: brset = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   function automatic avrdec_pkg::mnemonic_type brclr(input logic [2:0] c);
      case (c)
         3'd0:    brclr = avrdec_pkg::MN_BRCC;
         3'd1:    brclr = avrdec_pkg::MN_BRNE;
         3'd2:    brclr = avrdec_pkg::MN_BRPL;
         3'd4:    brclr = avrdec_pkg::MN_BRGE;
         3'd6:    brclr = avrdec_pkg::MN_BRTC;
         default: brclr = avrdec_pkg::MN_INVALID;
      endcase
   endfunction

   always_comb begin
      if ((hi == 8'h90 || hi == 8'h91) && b2[3:0] == 4'h0) begin
         mnemonic = avrdec_pkg::MN_LDS;
      end else if ((hi == 8'h92 || hi == 8'h93) && b2[3:0] == 4'h0) begin
         mnemonic = avrdec_pkg::MN_STS;
      end else if ((hi == 8'h94 || hi == 8'h95) && (b2 == 8'h0C || b2 == 8'h0D)) begin
         mnemonic = avrdec_pkg::MN_JMP;
      end else if ((hi == 8'h94 || hi == 8'h95) && (b2 == 8'h0E || b2 == 8'h0F)) begin
         mnemonic = avrdec_pkg::MN_CALL;
      end else if (major == 8'h95 && minor == 8'h98) begin
         mnemonic = avrdec_pkg::MN_BREAK;
      end else if (major == 8'h00) begin
         mnemonic = (minor == 8'h00) ? avrdec_pkg::MN_NOP : avrdec_pkg::MN_INVALID;
      end else if (major == 8'h01) begin
         mnemonic = avrdec_pkg::MN_MOVW;
      end else if (major <= 8'h03) begin
         mnemonic = avrdec_pkg::MN_MULS;
      end else if (major <= 8'h2F) begin
         mnemonic = quad_group(major[5:2]);
      end else if (major <= 8'h7F) begin
         mnemonic = imm_group(major[6:4]);
      end else if (major <= 8'h8F || (major >= 8'hA0 && major <= 8'hAF)) begin
         mnemonic = major[1] ? avrdec_pkg::MN_STD : avrdec_pkg::MN_LDD;
      end else if (major <= 8'h91) begin
         mnemonic = load_nib(nib);
      end else if (major <= 8'h93) begin
         mnemonic = store_nib(nib);
      end else if (major <= 8'h95) begin
         mnemonic = decode_9x({major, minor});
      end else if (major == 8'h96) begin
         mnemonic = avrdec_pkg::MN_ADIW;
      end else if (major == 8'h97) begin
         mnemonic = avrdec_pkg::MN_SBIW;
      end else if (major == 8'h98) begin
         mnemonic = avrdec_pkg::MN_CBI;
      end else if (major == 8'h99) begin
         mnemonic = avrdec_pkg::MN_INVALID;
      end else if (major == 8'h9A) begin
         mnemonic = avrdec_pkg::MN_SBI;
      end else if (major == 8'h9B) begin
         mnemonic = avrdec_pkg::MN_SBIS;
      end else if (major <= 8'h9F) begin
         mnemonic = avrdec_pkg::MN_MUL;
      end else if (major <= 8'hB7) begin
         mnemonic = avrdec_pkg::MN_IN;
      end else if (major <= 8'hBF) begin
         mnemonic = avrdec_pkg::MN_OUT;
      end else if (major <= 8'hCF) begin
         mnemonic = (major == 8'hCF && minor == 8'hFF) ? avrdec_pkg::MN_EXIT
                                                        : avrdec_pkg::MN_RJMP;
      end else if (major <= 8'hDF) begin
         mnemonic = avrdec_pkg::MN_RCALL;
      end else if (major <= 8'hEF) begin
         mnemonic = avrdec_pkg::MN_LDI;
      end else if (major <= 8'hF3) begin
         mnemonic = brset(minor[2:0]);
      end else if (major <= 8'hF7) begin
         mnemonic = brclr(minor[2:0]);
      end else if (major <= 8'hF9) begin
         mnemonic = nib[3] ? avrdec_pkg::MN_INVALID : avrdec_pkg::MN_BLD;
      end else if (major <= 8'hFB) begin
         mnemonic = avrdec_pkg::MN_BST;
      end else if (major <= 8'hFD) begin
         mnemonic = avrdec_pkg::MN_SBRC;
      end else begin
         mnemonic = avrdec_pkg::MN_SBRS;
      end
   end

endmodule

// File: rtl/avr_opcode_mnemonic_decoder.sv
// ----------------------------------------------------------------------------
// avr_opcode_mnemonic_decoder
// Opcode word register, decode, mnemonic result register.
//
//   channel   direction  signals
//   req       in         req_valid, req_ready, req_opcode_word[31:0]
//   rsp       out        rsp_valid, rsp_ready, rsp_mnemonic[6:0]
//
// One transaction per cycle sustained while rsp_ready stays high; an accepted
// word passes the input register, then the decode into the result register.
// Synchronous reset empties both stages.
// A stalled rsp holds its result; the input stage keeps accepting until
// both stages are full, so req_ready drops only with rsp_ready low.
// ----------------------------------------------------------------------------
module avr_opcode_mnemonic_decoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [avrdec_pkg::OPCODE_W-1:0]        req_opcode_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [avrdec_pkg::MNEMONIC_W-1:0]      rsp_mnemonic
);

   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   logic [avrdec_pkg::OPCODE_W-1:0]     s1_opcode_ff;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   avrdec_pkg::mnemonic_type            rsp_mnemonic_ff;
   avrdec_pkg::mnemonic_type            rsp_mnemonic_in;
   logic                                s2_load;
   logic                                s1_load;

   avrdec_core u_core (
      .opcode_word (s1_opcode_ff),
      .mnemonic    (rsp_mnemonic_in)
   );

   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign s1_load   = req_valid && req_ready;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_opcode_ff <= req_opcode_word;
      end
      if (s2_load) begin
         rsp_mnemonic_ff <= rsp_mnemonic_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mnemonic = rsp_mnemonic_ff;

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      s1_load |=> s1_valid_ff)
      else $error("accepted transaction not held in input stage");

   a_s2_load_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid_ff)
      else $error("decoded transaction not presented on rsp");

   a_full_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=>
         (s1_valid_ff && $stable(s1_opcode_ff)))
      else $error("input stage lost its transaction during a stall");

   a_ready_low_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a full stalled pipeline");

endmodule
